[rtl/core/urbfc_pkg.sv]
package urbfc_pkg;

  // field widths of one beat
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SLOTS_W  = 5;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEVEL_W  = 5;
  localparam int unsigned WORD_W   = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_WORD = 1'd1;
  localparam logic [WORD_W-1:0]    CHECK_WORD_RST = 16'hB0BA;

  // commands
  localparam logic [CMD_W-1:0] CMD_PUT      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TX_READY = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RX_BYTE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GET      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET_MSG  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PURGE    = 3'd5;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_TX_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RX_BYTE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MSG     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TX_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RX_OVERRUN = 2'd3;

  // drain and frame sequencing
  localparam int unsigned MAX_DRAIN   = 16;
  localparam int unsigned DRAIN_W     = 5;
  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned FRAME_CNT_W = 4;

  typedef enum logic [1:0] {
    BSRC_ZERO,
    BSRC_ITEM,
    BSRC_TX_RD,
    BSRC_RX_RD
  } byte_src_e;

  typedef struct packed {
    logic                take;
    logic                tx_push;
    logic                tx_pop;
    logic                rx_push;
    logic                rx_pop;
    logic                frame_shift;
    logic                purge;
    logic                irq_set;
    logic                irq_drain;
    logic                emit;
    logic [KIND_W-1:0]   kind;
    logic [STATUS_W-1:0] status;
    byte_src_e           byte_src;
    logic                msg;
    logic                last;
  } dp_cmd_t;

  typedef struct packed {
    logic               item_valid;
    logic [CMD_W-1:0]   cmd;
    logic               tx_empty;
    logic               tx_full;
    logic               slots_zero;
    logic               rx_empty;
    logic               rx_full;
    logic               rx_has_frame;
    logic [DRAIN_W-1:0] drain_n;
    logic               out_free;
  } dp_stat_t;

endpackage

[rtl/core/urbfc_if.sv]
interface urbfc_item_if import urbfc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [BYTE_W-1:0]  data_byte;
  logic [SLOTS_W-1:0] tx_slots;

  modport source (output valid, output cmd, output data_byte, output tx_slots, input ready);
  modport sink (input valid, input cmd, input data_byte, input tx_slots, output ready);
endinterface

interface urbfc_result_if import urbfc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [BYTE_W-1:0]   out_byte;
  logic [STATUS_W-1:0] status;
  logic [LEVEL_W-1:0]  rx_level;
  logic                tx_pending;
  logic [BYTE_W-1:0]   msg_device;
  logic [BYTE_W-1:0]   msg_command;
  logic [WORD_W-1:0]   msg_high16;
  logic [WORD_W-1:0]   msg_low16;
  logic                msg_valid;
  logic                last;

  modport source (
    output valid, output kind, output out_byte, output status, output rx_level,
    output tx_pending, output msg_device, output msg_command, output msg_high16,
    output msg_low16, output msg_valid, output last, input ready
  );
  modport sink (
    input valid, input kind, input out_byte, input status, input rx_level,
    input tx_pending, input msg_device, input msg_command, input msg_high16,
    input msg_low16, input msg_valid, input last, output ready
  );
endinterface

[rtl/core/uart_ring_buffers_with_frame_check_top.sv]
// a drain pops each byte from the transmit ring through its registered read port,
// then emits it; a message reads 8 bytes of the receive ring into the frame register
// and shifts the last byte in before its result is emitted
// reset: pointers, fill counts, tx pending flag clear; id 0, check word 0xb0ba
module uart_ring_buffers_with_frame_check_top import urbfc_pkg::*; #(
  parameter int unsigned TX_DEPTH = 16,
  parameter int unsigned RX_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  urbfc_item_if.sink            item_i,
  urbfc_result_if.source        result_o
);

  // command and status between sequencer and datapath
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer: one beat at a time, walks drains and frame reads
  urbfc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd)
  );

  // datapath: rings, pointers, config registers, frame register, output register
  urbfc_dp #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_s     (item_i),
    .result_m   (result_o),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat)
  );

endmodule

[rtl/core/urbfc_dp.sv]
module urbfc_dp import urbfc_pkg::*; #(
  parameter int unsigned TX_DEPTH = 16,
  parameter int unsigned RX_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  urbfc_item_if.sink            item_s,
  urbfc_result_if.source        result_m,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o
);

  localparam int unsigned TX_AW = $clog2(TX_DEPTH);
  localparam int unsigned TX_CW = $clog2(TX_DEPTH + 1);
  localparam int unsigned RX_AW = $clog2(RX_DEPTH);
  localparam int unsigned RX_CW = $clog2(RX_DEPTH + 1);
  localparam int unsigned CMPW  = (TX_CW > DRAIN_W) ? TX_CW : DRAIN_W;
  localparam int unsigned LVW   = (RX_CW > LEVEL_W) ? RX_CW : LEVEL_W;
  localparam int unsigned FW    = FRAME_BYTES * BYTE_W;

  // ring storage
  logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
  logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0] tx_rd_q, rx_rd_q;

  logic [TX_AW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [TX_CW-1:0] tx_fill_q, tx_fill_d;
  logic [RX_AW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [RX_CW-1:0] rx_fill_q, rx_fill_d;
  logic             irq_q, irq_d;

  logic [BYTE_W-1:0] own_id_q;
  logic [WORD_W-1:0] check_q;

  logic [CMD_W-1:0]   item_cmd_q;
  logic [BYTE_W-1:0]  item_data_q;
  logic [SLOTS_W-1:0] item_slots_q;
  logic               capture;

  logic [FW-1:0] frame_q;

  logic                out_valid_q;
  logic [KIND_W-1:0]   kind_q;
  logic [BYTE_W-1:0]   out_byte_q, out_byte_d;
  logic [STATUS_W-1:0] status_q;
  logic [LEVEL_W-1:0]  level_q;
  logic                pend_q;
  logic [BYTE_W-1:0]   dev_q, cmdc_q;
  logic [WORD_W-1:0]   high_q, low_q;
  logic                mvalid_q, last_q;

  logic [SLOTS_W-1:0] cap;
  logic [CMPW-1:0]    fill_ext, cap_ext;
  logic               last_batch;
  logic [LVW-1:0]     level_ext;
  logic               frame_ok;

  assign capture     = item_s.valid && cmd_i.take;
  assign item_s.ready = cmd_i.take;

  // drain count: min of free line slots, queued bytes and the per-event bound
  assign cap        = (item_slots_q > SLOTS_W'(MAX_DRAIN)) ? SLOTS_W'(MAX_DRAIN) : item_slots_q;
  assign fill_ext   = CMPW'(tx_fill_q);
  assign cap_ext    = CMPW'(cap);
  assign last_batch = fill_ext <= cap_ext;

  assign stat_o.item_valid   = item_s.valid;
  assign stat_o.cmd          = item_cmd_q;
  assign stat_o.tx_empty     = tx_fill_q == '0;
  assign stat_o.tx_full      = tx_fill_q == TX_CW'(TX_DEPTH);
  assign stat_o.slots_zero   = item_slots_q == '0;
  assign stat_o.rx_empty     = rx_fill_q == '0;
  assign stat_o.rx_full      = rx_fill_q == RX_CW'(RX_DEPTH);
  assign stat_o.rx_has_frame = rx_fill_q >= RX_CW'(FRAME_BYTES);
  assign stat_o.drain_n      = last_batch ? fill_ext[DRAIN_W-1:0] : cap[DRAIN_W-1:0];
  assign stat_o.out_free     = !out_valid_q || result_m.ready;

  // ring pointer updates
  always_comb begin
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    tx_fill_d = tx_fill_q;
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    rx_fill_d = rx_fill_q;
    irq_d     = irq_q;
    if (cmd_i.tx_push) begin
      tx_tail_d = (tx_tail_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_q + 1'b1;
      tx_fill_d = tx_fill_q + 1'b1;
    end
    if (cmd_i.tx_pop) begin
      tx_head_d = (tx_head_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_q + 1'b1;
      tx_fill_d = tx_fill_q - 1'b1;
    end
    if (cmd_i.rx_push) begin
      rx_tail_d = (rx_tail_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_q + 1'b1;
      rx_fill_d = rx_fill_q + 1'b1;
    end
    if (cmd_i.rx_pop) begin
      rx_head_d = (rx_head_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_q + 1'b1;
      rx_fill_d = rx_fill_q - 1'b1;
    end
    if (cmd_i.purge) begin
      tx_head_d = '0;
      tx_tail_d = '0;
      tx_fill_d = '0;
      rx_head_d = '0;
      rx_tail_d = '0;
      rx_fill_d = '0;
    end
    if (cmd_i.irq_set) begin
      irq_d = 1'b1;
    end
    if (cmd_i.irq_drain && last_batch) begin
      irq_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_head_q <= '0;
      tx_tail_q <= '0;
      tx_fill_q <= '0;
      rx_head_q <= '0;
      rx_tail_q <= '0;
      rx_fill_q <= '0;
      irq_q     <= 1'b0;
    end else begin
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      tx_fill_q <= tx_fill_d;
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      rx_fill_q <= rx_fill_d;
      irq_q     <= irq_d;
    end
  end

  // memories, registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.tx_push) begin
      tx_mem[tx_tail_q] <= item_data_q;
    end
    if (cmd_i.tx_pop) begin
      tx_rd_q <= tx_mem[tx_head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rx_push) begin
      rx_mem[rx_tail_q] <= item_data_q;
    end
    if (cmd_i.rx_pop) begin
      rx_rd_q <= rx_mem[rx_head_q];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= '0;
      check_q  <= CHECK_WORD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OWN_ID:     own_id_q <= cfg_data_i[BYTE_W-1:0];
        REG_CHECK_WORD: check_q  <= cfg_data_i[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // accepted beat and frame assembly
  always_ff @(posedge clk_i) begin
    if (capture) begin
      item_cmd_q   <= item_s.cmd;
      item_data_q  <= item_s.data_byte;
      item_slots_q <= item_s.tx_slots;
    end
    if (cmd_i.frame_shift) begin
      frame_q <= {rx_rd_q, frame_q[FW-1:BYTE_W]};
    end
  end

  // output register
  assign level_ext = LVW'(rx_fill_q);
  assign frame_ok  = (frame_q[FW-1:FW-WORD_W] == check_q) && (frame_q[BYTE_W-1:0] == own_id_q);

  always_comb begin
    case (cmd_i.byte_src)
      BSRC_ITEM:  out_byte_d = item_data_q;
      BSRC_TX_RD: out_byte_d = tx_rd_q;
      BSRC_RX_RD: out_byte_d = rx_rd_q;
      default:    out_byte_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (result_m.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q     <= cmd_i.kind;
      out_byte_q <= out_byte_d;
      status_q   <= cmd_i.status;
      level_q    <= level_ext[LEVEL_W-1:0];
      pend_q     <= irq_q;
      last_q     <= cmd_i.last;
      dev_q      <= cmd_i.msg ? frame_q[BYTE_W-1:0] : '0;
      cmdc_q     <= cmd_i.msg ? frame_q[2*BYTE_W-1:BYTE_W] : '0;
      high_q     <= cmd_i.msg ? frame_q[4*BYTE_W-1:2*BYTE_W] : '0;
      low_q      <= cmd_i.msg ? frame_q[6*BYTE_W-1:4*BYTE_W] : '0;
      mvalid_q   <= cmd_i.msg && frame_ok;
    end
  end

  assign result_m.valid       = out_valid_q;
  assign result_m.kind        = kind_q;
  assign result_m.out_byte    = out_byte_q;
  assign result_m.status      = status_q;
  assign result_m.rx_level    = level_q;
  assign result_m.tx_pending  = pend_q;
  assign result_m.msg_device  = dev_q;
  assign result_m.msg_command = cmdc_q;
  assign result_m.msg_high16  = high_q;
  assign result_m.msg_low16   = low_q;
  assign result_m.msg_valid   = mvalid_q;
  assign result_m.last        = last_q;

`ifndef SYNTHESIS
  a_tx_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tx_pop |-> tx_fill_q != '0)
    else $error("tx pop on empty ring");
  a_rx_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rx_pop |-> rx_fill_q != '0)
    else $error("rx pop on empty ring");
  a_tx_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tx_push |-> tx_fill_q != TX_CW'(TX_DEPTH))
    else $error("tx push into full ring");
`endif

endmodule

[rtl/core/urbfc_ctrl.sv]
module urbfc_ctrl import urbfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_FRAME  = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [DRAIN_W-1:0]     drain_q, drain_d;
  logic [FRAME_CNT_W-1:0] fcnt_q, fcnt_d;
  logic [KIND_W-1:0]      kind_q, kind_d;
  logic [STATUS_W-1:0]    rstat_q, rstat_d;
  byte_src_e              src_q, src_d;
  logic                   msg_q, msg_d;

  always_comb begin
    state_d = state_q;
    drain_d = drain_q;
    fcnt_d  = fcnt_q;
    kind_d  = kind_q;
    rstat_d = rstat_q;
    src_d   = src_q;
    msg_d   = msg_q;
    cmd_o          = '0;
    cmd_o.kind     = kind_q;
    cmd_o.status   = rstat_q;
    cmd_o.byte_src = src_q;
    cmd_o.msg      = msg_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.take = 1'b1;
        if (stat_i.item_valid) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_EMIT;
        kind_d  = KIND_STATUS;
        rstat_d = ST_OK;
        src_d   = BSRC_ZERO;
        msg_d   = 1'b0;
        case (stat_i.cmd)
          CMD_PUT: begin
            if (stat_i.tx_full) begin
              rstat_d = ST_TX_FULL;
            end else if (stat_i.tx_empty && !stat_i.slots_zero) begin
              kind_d = KIND_TX_BYTE;
              src_d  = BSRC_ITEM;
            end else begin
              cmd_o.tx_push = 1'b1;
              cmd_o.irq_set = 1'b1;
            end
          end
          CMD_TX_READY: begin
            cmd_o.irq_drain = 1'b1;
            if (stat_i.drain_n != '0) begin
              drain_d = stat_i.drain_n;
              kind_d  = KIND_TX_BYTE;
              src_d   = BSRC_TX_RD;
              state_d = S_DRAIN;
            end
          end
          CMD_RX_BYTE: begin
            if (stat_i.rx_full) begin
              rstat_d = ST_RX_OVERRUN;
            end else begin
              cmd_o.rx_push = 1'b1;
            end
          end
          CMD_GET: begin
            if (stat_i.rx_empty) begin
              rstat_d = ST_EMPTY;
            end else begin
              cmd_o.rx_pop = 1'b1;
              kind_d       = KIND_RX_BYTE;
              src_d        = BSRC_RX_RD;
            end
          end
          CMD_GET_MSG: begin
            if (!stat_i.rx_has_frame) begin
              rstat_d = ST_EMPTY;
            end else begin
              kind_d  = KIND_MSG;
              msg_d   = 1'b1;
              fcnt_d  = '0;
              state_d = S_FRAME;
            end
          end
          CMD_PURGE: begin
            cmd_o.purge = 1'b1;
          end
          default: ;
        endcase
      end
      S_DRAIN: begin
        cmd_o.tx_pop = 1'b1;
        state_d      = S_EMIT;
      end
      S_FRAME: begin
        // read one byte a cycle, shift in the byte read the cycle before
        cmd_o.rx_pop      = fcnt_q < FRAME_CNT_W'(FRAME_BYTES);
        cmd_o.frame_shift = fcnt_q != '0;
        if (fcnt_q == FRAME_CNT_W'(FRAME_BYTES)) begin
          cmd_o.purge = 1'b1;
          state_d     = S_EMIT;
        end else begin
          fcnt_d = fcnt_q + 1'b1;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = drain_q <= DRAIN_W'(1);
          if (drain_q > DRAIN_W'(1)) begin
            drain_d = drain_q - 1'b1;
            state_d = S_DRAIN;
          end else begin
            drain_d = '0;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      drain_q <= '0;
      fcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      drain_q <= drain_d;
      fcnt_q  <= fcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    rstat_q <= rstat_d;
    src_q   <= src_d;
    msg_q   <= msg_d;
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> stat_i.out_free)
    else $error("result loaded while output register busy");
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && stat_i.item_valid) |=> state_q == S_DECODE)
    else $error("accepted beat not decoded");
  a_drain_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_q != '0) |-> (state_q == S_DRAIN || state_q == S_EMIT))
    else $error("drain count live outside drain");
`endif

endmodule
